FILE: rtl/core/sesh_pkg.sv
`timescale 1ns / 1ps

package sesh_pkg;

  localparam int LOG_FRAC = 16;
  localparam int COUNT_W = 16;
  localparam int COLOR_W = 24;
  localparam int IDX_W = 4;
  localparam int COORD_W = 32;
  localparam int SQ_W = 2 * COORD_W;
  localparam int S_W = COUNT_W + 1 + LOG_FRAC;
  localparam int REM_W = S_W - LOG_FRAC;
  localparam int MAXI_W = 16;
  localparam int SIZE_W = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SHADE = 1'b1;

  localparam logic REG_ITER_LIMIT = 1'b0;
  localparam logic REG_PAL_SIZE = 1'b1;

  localparam logic [MAXI_W-1:0] ITER_LIMIT_RESET = 16'd256;
  localparam logic [SIZE_W-1:0] PAL_SIZE_RESET = 5'd8;

  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
    logic [SQ_W-1:0]    sqx;
    logic [SQ_W-1:0]    sqy;
  } item_t;

  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
    logic               big;
  } side_t;

endpackage

FILE: rtl/core/sesh_front.sv
`timescale 1ns / 1ps

module sesh_front import sesh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic                      operation,
  input  logic [IDX_W-1:0]          entry_index,
  input  logic [COLOR_W-1:0]        entry_color,
  input  logic [COUNT_W-1:0]        escape_count,
  input  logic signed [COORD_W-1:0] z_real,
  input  logic signed [COORD_W-1:0] z_imag,
  output logic                      push,
  output item_t                     push_item,
  input  logic                      full
);

  logic                held;
  item_t               hold;
  logic [COORD_W-1:0]  ax;
  logic [COORD_W-1:0]  ay;
  logic                take;

  assign ax = z_real[COORD_W-1] ? COORD_W'(-z_real) : COORD_W'(z_real);
  assign ay = z_imag[COORD_W-1] ? COORD_W'(-z_imag) : COORD_W'(z_imag);

  assign push       = held && !full;
  assign item_ready = !held || !full;
  assign take       = item_valid && item_ready;
  assign push_item  = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold.op    <= operation;
      hold.idx   <= entry_index;
      hold.color <= entry_color;
      hold.count <= escape_count;
      hold.sqx   <= SQ_W'(ax) * SQ_W'(ax);
      hold.sqy   <= SQ_W'(ay) * SQ_W'(ay);
    end
  end

endmodule

FILE: rtl/core/sesh_queue.sv
`timescale 1ns / 1ps

module sesh_queue import sesh_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  nonempty,
  output item_t pop_item
);

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full     = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign pop_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

FILE: rtl/core/sesh_log2.sv
`timescale 1ns / 1ps

module sesh_log2 import sesh_pkg::*; #(
  parameter int IN_W = 64,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [SIDE_W-1:0]                 in_side,
  input  logic [IN_W-1:0]                   x,
  output logic                              out_valid,
  output logic [SIDE_W-1:0]                 out_side,
  output logic [$clog2(IN_W)+LOG_FRAC-1:0]  r
);

  localparam int E_W = $clog2(IN_W);
  localparam int OUT_W = E_W + LOG_FRAC;
  localparam int NST = LOG_FRAC + 2;
  localparam logic [E_W-1:0] TOP = E_W'(IN_W - 1);

  logic [NST-1:0]    v;
  logic [SIDE_W-1:0] side [NST];
  logic [IN_W-1:0]   xa;
  logic [E_W-1:0]    ea;
  logic [E_W-1:0]    e_in;
  logic [E_W-1:0]    lz;
  logic [IN_W-1:0]   norm;
  logic [IN_W+31:0]  ext;
  logic [31:0]       ys [1:NST-2];
  logic [OUT_W-1:0]  rs [1:NST-1];
  logic [63:0]       sq [LOG_FRAC];
  logic [32:0]       z [LOG_FRAC];

  always_comb begin
    e_in = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (x[i]) begin
        e_in = E_W'(i);
      end
    end
  end

  assign lz   = TOP - ea;
  assign norm = xa << lz;
  assign ext  = {norm, 32'b0};

  always_comb begin
    for (int k = 0; k < LOG_FRAC; k++) begin
      sq[k] = 64'(ys[k+1]) * 64'(ys[k+1]);
      z[k]  = sq[k][63:31];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int i = 1; i < NST; i++) begin
        side[i] <= side[i-1];
      end
      xa    <= x;
      ea    <= e_in;
      ys[1] <= ext[IN_W+31 -: 32];
      rs[1] <= {ea, LOG_FRAC'(0)};
      for (int k = 0; k < LOG_FRAC - 1; k++) begin
        ys[k+2] <= z[k][32] ? z[k][32:1] : z[k][31:0];
      end
      for (int k = 0; k < LOG_FRAC; k++) begin
        rs[k+2] <= rs[k+1] | (OUT_W'(z[k][32]) << (LOG_FRAC - 1 - k));
      end
    end
  end

  assign out_valid = v[NST-1];
  assign out_side  = side[NST-1];
  assign r         = rs[NST-1];

endmodule

FILE: rtl/core/sesh_back.sv
`timescale 1ns / 1ps

module sesh_back import sesh_pkg::*; #(
  parameter int PALETTE_DEPTH = 16,
  parameter int COORD_FRAC_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  output logic                             q_pop,
  input  item_t                            q_item,
  input  logic [MAXI_W-1:0]                maxi,
  input  logic [$clog2(PALETTE_DEPTH)-1:0] segs,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [COLOR_W-1:0]               pixel_color
);

  localparam int SEG_W = $clog2(PALETTE_DEPTH);
  localparam int Q_W = SEG_W + LOG_FRAC;
  localparam int PROD_W = S_W + SEG_W;
  localparam int SIDE_W = $bits(side_t);
  localparam int L1_W = $clog2(SQ_W) + LOG_FRAC;
  localparam int L2_W = $clog2(L1_W) + LOG_FRAC;
  localparam int CH_W = 8;
  localparam int ACC_W = CH_W + LOG_FRAC + 1;
  localparam logic [SQ_W-1:0] BIG_LIM = SQ_W'(4) << (2 * COORD_FRAC_BITS);
  localparam logic [L1_W-1:0] L2_SUB = L1_W'(2 * COORD_FRAC_BITS) << LOG_FRAC;
  localparam logic [L2_W-1:0] NU_BASE = L2_W'(LOG_FRAC + 1) << LOG_FRAC;
  localparam logic [LOG_FRAC:0] ONE = {1'b1, LOG_FRAC'(0)};

  logic en;

  logic            v0;
  side_t           sb0;
  side_t           sb0_in;
  logic [SQ_W-1:0] mag2;
  logic [SQ_W-1:0] sum0;

  logic              v1;
  logic [SIDE_W-1:0] sb1_v;
  side_t             sb1;
  logic [L1_W-1:0]   r1;
  logic [L1_W-1:0]   l2;

  logic              v2;
  logic [SIDE_W-1:0] sb2_v;
  side_t             sb2;
  logic [L2_W-1:0]   r2;

  logic [L2_W-1:0] nu;
  logic [S_W-1:0]  s_full;
  logic [S_W-1:0]  s_in;
  logic            v3;
  side_t           sb3;
  logic [S_W-1:0]  s3;

  logic [PROD_W-1:0] prod;
  logic              over_in;

  logic [Q_W:0]     vd;
  side_t            sb_d [Q_W+1];
  logic             over_d [Q_W+1];
  logic [Q_W-1:0]   low_d [Q_W+1];
  logic [REM_W-1:0] rem_d [Q_W];
  logic [REM_W:0]   dt [Q_W];
  logic             dge [Q_W];
  side_t            sbq;

  logic [SEG_W-1:0]       seg;
  logic [LOG_FRAC:0]      tw;
  logic [COLOR_W-1:0]     pal [PALETTE_DEPTH];
  logic [SEG_W+IDX_W-1:0] widx;
  logic [SEG_W-1:0]       waddr;
  logic                   wr_ok;

  logic               sh6;
  logic [COLOR_W-1:0] lo6;
  logic [COLOR_W-1:0] hi6;
  logic [LOG_FRAC:0]  t6;
  logic [ACC_W-1:0]   acc [3];
  logic [COLOR_W-1:0] blend;

  assign en    = !result_valid || result_ready;
  assign q_pop = q_valid && en;

  assign sum0 = q_item.sqx + q_item.sqy;

  always_comb begin
    sb0_in.op    = q_item.op;
    sb0_in.idx   = q_item.idx;
    sb0_in.color = q_item.color;
    sb0_in.count = q_item.count;
    sb0_in.big   = sum0 > BIG_LIM;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb0  <= sb0_in;
      mag2 <= sum0;
    end
  end

  sesh_log2 #(
    .IN_W   (SQ_W),
    .SIDE_W (SIDE_W)
  ) u_log_mag (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v0),
    .in_side   (sb0),
    .x         (mag2),
    .out_valid (v1),
    .out_side  (sb1_v),
    .r         (r1)
  );

  assign sb1 = side_t'(sb1_v);
  assign l2  = r1 - L2_SUB;

  sesh_log2 #(
    .IN_W   (L1_W),
    .SIDE_W (SIDE_W)
  ) u_log_log (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .in_side   (sb1),
    .x         (l2),
    .out_valid (v2),
    .out_side  (sb2_v),
    .r         (r2)
  );

  assign sb2 = side_t'(sb2_v);

  always_comb begin
    nu     = (sb2.big && r2 > NU_BASE) ? r2 - NU_BASE : '0;
    s_full = {REM_W'(sb2.count) + 1'b1, LOG_FRAC'(0)};
    s_in   = (s_full > S_W'(nu)) ? s_full - S_W'(nu) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb3 <= sb2;
      s3  <= s_in;
    end
  end

  assign prod    = PROD_W'(s3) * PROD_W'(segs);
  assign over_in = s3 >= S_W'({maxi, LOG_FRAC'(0)});

  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      dt[k]  = {rem_d[k], low_d[k][Q_W-1]};
      dge[k] = dt[k] >= (REM_W+1)'(maxi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (en) begin
      vd <= {vd[Q_W-1:0], v3};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_d[0]   <= sb3;
      over_d[0] <= over_in;
      rem_d[0]  <= prod[PROD_W-1:Q_W];
      low_d[0]  <= prod[Q_W-1:0];
      for (int k = 0; k < Q_W; k++) begin
        sb_d[k+1]   <= sb_d[k];
        over_d[k+1] <= over_d[k];
        low_d[k+1]  <= {low_d[k][Q_W-2:0], dge[k]};
      end
      for (int k = 0; k < Q_W - 1; k++) begin
        rem_d[k+1] <= dge[k] ? REM_W'(dt[k] - (REM_W+1)'(maxi)) : REM_W'(dt[k]);
      end
    end
  end

  assign sbq = sb_d[Q_W];

  always_comb begin
    if (over_d[Q_W]) begin
      seg = SEG_W'(segs - 1'b1);
      tw  = ONE;
    end else begin
      seg = low_d[Q_W][Q_W-1:LOG_FRAC];
      tw  = {1'b0, low_d[Q_W][LOG_FRAC-1:0]};
    end
  end

  assign widx  = {SEG_W'(0), sbq.idx};
  assign waddr = widx[SEG_W-1:0];
  assign wr_ok = vd[Q_W] && sbq.op == OP_WRITE && 32'(sbq.idx) < PALETTE_DEPTH;

  always_ff @(posedge clk) begin
    if (en && wr_ok) begin
      pal[waddr] <= sbq.color;
    end
    if (en) begin
      lo6 <= pal[seg];
      hi6 <= pal[SEG_W'(seg + 1'b1)];
      t6  <= tw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sh6 <= 1'b0;
    end else if (en) begin
      sh6 <= vd[Q_W] && sbq.op == OP_SHADE;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = ACC_W'(lo6[CH_W*c +: CH_W]) * ACC_W'(ONE - t6)
             + ACC_W'(hi6[CH_W*c +: CH_W]) * ACC_W'(t6);
      blend[CH_W*c +: CH_W] = acc[c][LOG_FRAC +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= sh6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_color <= blend;
    end
  end

endmodule

FILE: rtl/core/smooth_escape_palette_shader.sv
// The back pipeline holds two 18-stage log2 units and a one-bit-per-stage divider.
// One item is taken per cycle unless stalled; the back pipeline stalls only while its result register is held.
// Palette writes give no result and update the palette in order with shades at the read stage.
// Reset (rst, synchronous) empties the pipeline, sets max_iterations to 256 and palette_size to 8;
// palette contents are undefined until written.
`timescale 1ns / 1ps

module smooth_escape_palette_shader import sesh_pkg::*; #(
  parameter int PALETTE_DEPTH = 16,
  parameter int COORD_FRAC_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic                      operation,
  input  logic [IDX_W-1:0]          entry_index,
  input  logic [COLOR_W-1:0]        entry_color,
  input  logic [COUNT_W-1:0]        escape_count,
  input  logic signed [COORD_W-1:0] z_real,
  input  logic signed [COORD_W-1:0] z_imag,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [COLOR_W-1:0]        pixel_color,
  input  logic                      write_enable,
  input  logic                      reg_index,
  input  logic [MAXI_W-1:0]         write_data
);

  localparam int SEG_W = $clog2(PALETTE_DEPTH);

  logic [MAXI_W-1:0] max_iterations;
  logic [SIZE_W-1:0] palette_size;
  logic [MAXI_W-1:0] maxi;
  logic [SEG_W:0]    size_c;
  logic [SEG_W-1:0]  segs;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_pop;
  logic  q_nonempty;
  item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= ITER_LIMIT_RESET;
      palette_size   <= PAL_SIZE_RESET;
    end else if (write_enable) begin
      case (reg_index)
        REG_ITER_LIMIT: max_iterations <= write_data;
        REG_PAL_SIZE:   palette_size   <= write_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign maxi = (max_iterations == '0) ? MAXI_W'(1) : max_iterations;

  always_comb begin
    if (32'(palette_size) < 32'd2) begin
      size_c = (SEG_W+1)'(2);
    end else if (32'(palette_size) > PALETTE_DEPTH) begin
      size_c = (SEG_W+1)'(PALETTE_DEPTH);
    end else begin
      size_c = (SEG_W+1)'(palette_size);
    end
  end

  assign segs = SEG_W'(size_c - 1'b1);

  sesh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .operation    (operation),
    .entry_index  (entry_index),
    .entry_color  (entry_color),
    .escape_count (escape_count),
    .z_real       (z_real),
    .z_imag       (z_imag),
    .push         (push),
    .push_item    (push_item),
    .full         (q_full)
  );

  sesh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_item  (q_item)
  );

  sesh_back #(
    .PALETTE_DEPTH   (PALETTE_DEPTH),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_nonempty),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .maxi         (maxi),
    .segs         (segs),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_color  (pixel_color)
  );

endmodule

FILE: rtl/core/sesh_checker.sv
`timescale 1ns / 1ps

module sesh_checker import sesh_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               operation,
  input logic               result_valid,
  input logic               result_ready,
  input logic [COLOR_W-1:0] pixel_color
);

  logic [15:0] pend;
  logic        shade_in;
  logic        result_out;

  assign shade_in   = item_valid && item_ready && operation == OP_SHADE;
  assign result_out = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      case ({shade_in, result_out})
        2'b10:   pend <= pend + 1'b1;
        2'b01:   pend <= pend - 1'b1;
        default: pend <= pend;
      endcase
    end
  end

  a_reset_no_result: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> item_ready)
    else $error("input not ready right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(pixel_color))
    else $error("stalled result beat changed");

  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pend != '0)
    else $error("result beat without an outstanding shade item");

endmodule

bind smooth_escape_palette_shader sesh_checker u_sesh_checker (.*);

FILE: tb/sv/shade_checker.sv
`timescale 1ns / 1ps

module shade_checker import sesh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  input  logic                      item_ready,
  input  logic                      operation,
  input  logic [IDX_W-1:0]          entry_index,
  input  logic [COLOR_W-1:0]        entry_color,
  input  logic [COUNT_W-1:0]        escape_count,
  input  logic signed [COORD_W-1:0] z_real,
  input  logic signed [COORD_W-1:0] z_imag,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  logic [COLOR_W-1:0]        pixel_color,
  input  logic                      write_enable,
  input  logic                      reg_index,
  input  logic [MAXI_W-1:0]         write_data,
  output int                        errors,
  output int                        pending
);

  localparam int DEPTH = 16;
  localparam int FRAC = 24;

  logic [MAXI_W-1:0]  iter_limit;
  logic [SIZE_W-1:0]  pal_size;
  logic [COLOR_W-1:0] palette [DEPTH];
  logic [COLOR_W-1:0] expected_colors [$];

  function automatic logic [63:0] log2_fix(input logic [63:0] x);
    int e;
    logic [63:0] y;
    logic [63:0] r;
    if (x == 0) return 64'd0;
    e = 63;
    while (!x[e]) e--;
    y = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
    r = 64'(e) << LOG_FRAC;
    for (int k = LOG_FRAC - 1; k >= 0; k--) begin
      y = (y * y) >> 31;
      if (y >= 64'h1_0000_0000) begin
        r[k] = 1'b1;
        y = y >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] magnitude(input logic [COORD_W-1:0] v);
    logic [63:0] m;
    m = {32'd0, v};
    if (v[COORD_W-1]) m = (~m + 64'd1) & 64'hFFFF_FFFF;
    return m;
  endfunction

  function automatic logic [COLOR_W-1:0] shade_color(input logic [COUNT_W-1:0] cnt,
                                                    input logic [COORD_W-1:0] zr,
                                                    input logic [COORD_W-1:0] zi);
    logic [63:0] ax, ay, mag2, nu, l2, lg, s, pos, t, segs, maxi, mix;
    logic [63:0] base;
    int size, seg;
    logic [COLOR_W-1:0] lo, hi, rgb;
    ax = magnitude(zr);
    ay = magnitude(zi);
    mag2 = ax * ax + ay * ay;
    nu = 0;
    if (mag2 > (64'd4 << (2 * FRAC))) begin
      l2 = log2_fix(mag2) - (64'(2 * FRAC) << LOG_FRAC);
      lg = log2_fix(l2);
      base = 64'(LOG_FRAC + 1) << LOG_FRAC;
      nu = (lg > base) ? lg - base : 64'd0;
    end
    s = (64'(cnt) + 64'd1) << LOG_FRAC;
    s = (s > nu) ? s - nu : 64'd0;
    size = int'(pal_size);
    if (size < 2) size = 2;
    if (size > DEPTH) size = DEPTH;
    segs = 64'(size - 1);
    maxi = (iter_limit != 0) ? 64'(iter_limit) : 64'd1;
    pos = (s * segs) / maxi;
    if (pos >= (segs << LOG_FRAC)) begin
      seg = size - 2;
      t = 64'd1 << LOG_FRAC;
    end else begin
      seg = int'(pos >> LOG_FRAC);
      t = pos & 64'hFFFF;
    end
    lo = palette[seg];
    hi = palette[seg + 1];
    for (int sh = 0; sh <= 16; sh += 8) begin
      mix = 64'(lo[sh +: 8]) * ((64'd1 << LOG_FRAC) - t) + 64'(hi[sh +: 8]) * t;
      rgb[sh +: 8] = mix[LOG_FRAC +: 8];
    end
    return rgb;
  endfunction

  task automatic report_mismatch(input string what, input logic [COLOR_W-1:0] got,
                                 input logic [COLOR_W-1:0] want);
    $display("mismatch at %0t: %s got %06h expected %06h", $realtime, what, got, want);
    errors++;
  endtask

  assign pending = expected_colors.size();

  initial errors = 0;

  always @(posedge clk) begin
    if (rst) begin
      iter_limit <= ITER_LIMIT_RESET;
      pal_size <= PAL_SIZE_RESET;
      expected_colors.delete();
    end else begin
      if (write_enable) begin
        if (reg_index == REG_ITER_LIMIT) iter_limit <= write_data;
        else pal_size <= write_data[SIZE_W-1:0];
      end
      if (result_valid && result_ready) begin
        if (expected_colors.size() == 0) report_mismatch("unexpected beat", pixel_color, '0);
        else begin
          if (pixel_color !== expected_colors[0])
            report_mismatch("pixel_color", pixel_color, expected_colors[0]);
          void'(expected_colors.pop_front());
        end
      end
      if (item_valid && item_ready) begin
        if (operation == OP_WRITE) palette[entry_index] = entry_color;
        else expected_colors.push_back(shade_color(escape_count, z_real, z_imag));
      end
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sesh_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 90;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic operation = OP_WRITE;
  logic [IDX_W-1:0] entry_index = '0;
  logic [COLOR_W-1:0] entry_color = '0;
  logic [COUNT_W-1:0] escape_count = '0;
  logic signed [COORD_W-1:0] z_real = '0;
  logic signed [COORD_W-1:0] z_imag = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [COLOR_W-1:0] pixel_color;
  logic write_enable = 1'b0;
  logic reg_index = REG_ITER_LIMIT;
  logic [MAXI_W-1:0] write_data = '0;
  int errors;
  int pending;
  int cycles = 0;
  int results_seen = 0;
  int stall_left = 0;
  bit send_steady = 1'b0;
  int cur_maxi = 256;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  smooth_escape_palette_shader dut (.*);

  shade_checker checker_i (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("smooth_escape_palette_shader regression: fail");
      $finish;
    end
  end

  // Result side: random backpressure, one long hold-off, and a quiet stretch.
  initial begin
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) results_seen++;
      @(negedge clk);
      if (results_seen == 300 && stall_left == 0) stall_left = -400;
      if (stall_left < 0) begin
        stall_left++;
        result_ready <= 1'b0;
        if (stall_left == 0) stall_left = 1;
      end else if (results_seen >= 700 && results_seen < 900) result_ready <= 1'b1;
      else result_ready <= ($urandom_range(0, 99) >= 16);
    end
  end

  task automatic send_beat(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [COLOR_W-1:0] color, input logic [COUNT_W-1:0] cnt,
                           input logic [COORD_W-1:0] zr, input logic [COORD_W-1:0] zi);
    while (!send_steady && $urandom_range(0, 99) < 16) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    entry_index <= idx;
    entry_color <= color;
    escape_count <= cnt;
    z_real <= zr;
    z_imag <= zi;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [MAXI_W-1:0] value);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= value;
    @(negedge clk);
    write_enable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    logic [COORD_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h01FF_FFFF);
      2: v = $urandom_range(32'h0200_0000, 32'h1000_0000);
      3: v = $urandom_range(32'h1000_0000, 32'h7FFF_FFFF);
      4: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: v = $urandom_range(0, 32'h0300_0000);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic random_phase(input int count);
    logic [COUNT_W-1:0] cnt;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 15) begin
        send_beat(OP_WRITE, IDX_W'($urandom), COLOR_W'($urandom), COUNT_W'($urandom),
                  $urandom, $urandom);
      end else begin
        if ($urandom_range(0, 9) == 0) cnt = COUNT_W'($urandom);
        else cnt = COUNT_W'($urandom_range(0, (cur_maxi < 2) ? 2 : cur_maxi + 1));
        send_beat(OP_SHADE, IDX_W'($urandom), COLOR_W'($urandom), cnt, pick_coord(),
                  pick_coord());
      end
    end
  endtask

  int maxi_set [7] = '{65535, 1, 0, 100, 1000, 50, 65535};
  int size_set [7] = '{16, 2, 0, 31, 17, 1, 5};

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < 16; i++)
      send_beat(OP_WRITE, IDX_W'(i),
                (i == 0) ? 24'h000000 : (i == 15) ? 24'hFFFFFF : COLOR_W'($urandom),
                COUNT_W'($urandom), $urandom, $urandom);
    send_beat(OP_SHADE, '0, '0, 16'd0, 32'd0, 32'd0);
    send_beat(OP_SHADE, '0, '0, 16'hFFFF, 32'h8000_0000, 32'h8000_0000);
    send_beat(OP_SHADE, '0, '0, 16'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_beat(OP_SHADE, '0, '0, 16'd10, 32'h0200_0000, 32'd0);
    send_beat(OP_SHADE, '0, '0, 16'd10, 32'h0200_0001, 32'd0);
    send_beat(OP_SHADE, '0, '0, 16'd255, 32'hFE00_0000, 32'd0);
    send_beat(OP_SHADE, '0, '0, 16'd256, 32'h0400_0000, 32'hFC00_0000);
    send_beat(OP_SHADE, '0, '0, 16'd128, 32'h0300_0000, 32'h0100_0000);
    drain();

    random_phase(200);
    drain();
    for (int p = 0; p < 7; p++) begin
      write_reg(REG_ITER_LIMIT, MAXI_W'(maxi_set[p]));
      write_reg(REG_PAL_SIZE, {11'($urandom_range(0, 2047)), size_set[p][SIZE_W-1:0]});
      cur_maxi = maxi_set[p];
      send_steady = (p == 3);
      random_phase(200);
      drain();
    end

    if (errors == 0) $display("smooth_escape_palette_shader regression: pass");
    else $display("smooth_escape_palette_shader regression: fail");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sesh_pkg.sv
rtl/core/sesh_front.sv
rtl/core/sesh_queue.sv
rtl/core/sesh_log2.sv
rtl/core/sesh_back.sv
rtl/core/smooth_escape_palette_shader.sv
rtl/core/sesh_checker.sv
tb/sv/shade_checker.sv
tb/sv/tb_top.sv
